// ----- rtl/core/atatf_pkg.sv -----
// shared constants and types for the lba to task-file converter
`default_nettype none

package atatf_pkg;

    localparam int ADDRESS_BITS    = 28;
    localparam int COUNT_W         = 8;
    localparam int BYTE_W          = 8;
    localparam int SPT_W           = 8;
    localparam int HEAD_W          = 5;
    localparam int STEPS_PER_STAGE = 7;
    localparam int DIV_STAGES      = ADDRESS_BITS / STEPS_PER_STAGE;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LBA_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPT        = 2'd2;

    localparam logic              LBA_MODE_RESET = 1'b1;
    localparam logic [HEAD_W-1:0] HEAD_RESET     = 5'd16;
    localparam logic [HEAD_W-1:0] HEAD_MAX       = 5'd16;
    localparam logic [SPT_W-1:0]  SPT_RESET      = 8'd63;
    localparam logic [BYTE_W-1:0] LBA_FLAG       = 8'h40;

    typedef struct packed {
        logic [ADDRESS_BITS-1:0] lba;
        logic [COUNT_W-1:0]      cnt;
        logic [ADDRESS_BITS-1:0] work;
        logic [SPT_W-1:0]        rem_sector;
        logic [HEAD_W-1:0]       rem_head;
    } pipe_t;

endpackage

`default_nettype wire

// ----- rtl/core/atatf_div_stage.sv -----
// one pipeline stage of the restoring divider, a few quotient bits per stage
`default_nettype none

module atatf_div_stage #(
    parameter int PHASE = 0
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  atatf_pkg::pipe_t    in_data,
    input  wire [(PHASE == 0 ? atatf_pkg::SPT_W : atatf_pkg::HEAD_W)-1:0] divisor,
    output logic                out_valid,
    output atatf_pkg::pipe_t    out_data
);

    localparam int DIV_W = (PHASE == 0) ? atatf_pkg::SPT_W : atatf_pkg::HEAD_W;
    localparam int AW    = atatf_pkg::ADDRESS_BITS;

    logic             valid_reg;
    atatf_pkg::pipe_t data_reg;
    atatf_pkg::pipe_t data_next;
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] rem_out;
    logic [AW-1:0]    quo_out;

    always_comb begin
        logic [DIV_W-1:0] rem_v;
        logic [DIV_W:0]   ext;
        logic [AW-1:0]    quo;
        rem_v = rem_in;
        quo   = in_data.work;
        ext   = '0;
        for (int k = 0; k < atatf_pkg::STEPS_PER_STAGE; k++) begin
            ext = {rem_v, quo[AW-1]};
            quo = {quo[AW-2:0], 1'b0};
            if (ext >= {1'b0, divisor}) begin
                ext    = ext - {1'b0, divisor};
                quo[0] = 1'b1;
            end
            rem_v = ext[DIV_W-1:0];
        end
        rem_out = rem_v;
        quo_out = quo;
    end

    generate
        if (PHASE == 0) begin : g_spt
            assign rem_in = in_data.rem_sector;
            always_comb begin
                data_next            = in_data;
                data_next.work       = quo_out;
                data_next.rem_sector = rem_out;
            end
        end else begin : g_head
            assign rem_in = in_data.rem_head;
            always_comb begin
                data_next          = in_data;
                data_next.work     = quo_out;
                data_next.rem_head = rem_out;
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/atatf_fmt.sv -----
// output register that forms the five task-file bytes
`default_nettype none

module atatf_fmt (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 en,
    input  wire                 in_valid,
    input  atatf_pkg::pipe_t    in_data,
    input  wire                 lba_mode,
    output logic                out_valid,
    output logic [7:0]          count_byte,
    output logic [7:0]          sector_byte,
    output logic [7:0]          cyl_low_byte,
    output logic [7:0]          cyl_high_byte,
    output logic [7:0]          drive_head_byte
);

    logic       valid_reg;
    logic [7:0] cnt_reg,  cnt_next;
    logic [7:0] sec_reg,  sec_next;
    logic [7:0] clo_reg,  clo_next;
    logic [7:0] chi_reg,  chi_next;
    logic [7:0] dh_reg,   dh_next;

    always_comb begin
        cnt_next = in_data.cnt;
        if (lba_mode) begin
            sec_next = in_data.lba[7:0];
            clo_next = in_data.lba[15:8];
            chi_next = in_data.lba[23:16];
            dh_next  = {4'h0, in_data.lba[27:24]} | atatf_pkg::LBA_FLAG;
        end else begin
            sec_next = in_data.rem_sector + 8'd1;
            clo_next = in_data.work[7:0];
            chi_next = in_data.work[15:8];
            dh_next  = {3'b000, in_data.rem_head};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cnt_reg <= cnt_next;
            sec_reg <= sec_next;
            clo_reg <= clo_next;
            chi_reg <= chi_next;
            dh_reg  <= dh_next;
        end
    end

    assign out_valid       = valid_reg;
    assign count_byte      = cnt_reg;
    assign sector_byte     = sec_reg;
    assign cyl_low_byte    = clo_reg;
    assign cyl_high_byte   = chi_reg;
    assign drive_head_byte = dh_reg;

endmodule

`default_nettype wire

// ----- rtl/core/ata_lba_to_taskfile_top.sv -----
// top level of the lba to ata task-file converter
// structure: 8 divider stages, 1 output register; each divider stage retires 7 quotient bits,
// four stages divide by sectors per track, four more by head count
// throughput: one transaction per cycle unless m_ready holds back the output
// reset: synchronous active-low aresetn clears all valid bits and loads lba mode,
// 16 heads and 63 sectors per track
`default_nettype none

module ata_lba_to_taskfile_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [27:0] s_block_address,
    input  wire  [7:0]  s_sector_total,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_count_byte,
    output logic [7:0]  m_sector_byte,
    output logic [7:0]  m_cyl_low_byte,
    output logic [7:0]  m_cyl_high_byte,
    output logic [7:0]  m_drive_head_byte,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [atatf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [atatf_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NSTG = 2 * atatf_pkg::DIV_STAGES;

    logic                           lba_mode_reg;
    logic [atatf_pkg::HEAD_W-1:0]   head_reg;
    logic [atatf_pkg::SPT_W-1:0]    spt_reg;
    logic [atatf_pkg::HEAD_W-1:0]   heads_eff;
    logic [atatf_pkg::SPT_W-1:0]    spt_eff;

    atatf_pkg::pipe_t stage_data  [0:NSTG];
    logic             stage_valid [0:NSTG];
    logic             stage_en    [0:NSTG];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lba_mode_reg <= atatf_pkg::LBA_MODE_RESET;
            head_reg     <= atatf_pkg::HEAD_RESET;
            spt_reg      <= atatf_pkg::SPT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                atatf_pkg::CFG_LBA_MODE:   lba_mode_reg <= cfg_data[0];
                atatf_pkg::CFG_HEAD_COUNT: head_reg     <= cfg_data[atatf_pkg::HEAD_W-1:0];
                atatf_pkg::CFG_SPT:        spt_reg      <= cfg_data[atatf_pkg::SPT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (head_reg == '0) begin
            heads_eff = atatf_pkg::HEAD_W'(1);
        end else if (head_reg > atatf_pkg::HEAD_MAX) begin
            heads_eff = atatf_pkg::HEAD_MAX;
        end else begin
            heads_eff = head_reg;
        end
        spt_eff = (spt_reg == '0) ? atatf_pkg::SPT_W'(1) : spt_reg;
    end

    // pipeline entry
    assign stage_valid[0]           = s_valid;
    assign stage_data[0].lba        = s_block_address;
    assign stage_data[0].cnt        = s_sector_total;
    assign stage_data[0].work       = s_block_address;
    assign stage_data[0].rem_sector = '0;
    assign stage_data[0].rem_head   = '0;
    assign s_ready                  = stage_en[0];

    // a stage may load when it is empty or the one after it loads too
    assign stage_en[NSTG] = !m_valid || m_ready;

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_stage
            assign stage_en[g] = !stage_valid[g+1] || stage_en[g+1];
            if (g < atatf_pkg::DIV_STAGES) begin : g_spt
                atatf_div_stage #(.PHASE(0)) u_stage (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (stage_en[g]),
                    .in_valid  (stage_valid[g]),
                    .in_data   (stage_data[g]),
                    .divisor   (spt_eff),
                    .out_valid (stage_valid[g+1]),
                    .out_data  (stage_data[g+1])
                );
            end else begin : g_head
                atatf_div_stage #(.PHASE(1)) u_stage (
                    .aclk      (aclk),
                    .aresetn   (aresetn),
                    .en        (stage_en[g]),
                    .in_valid  (stage_valid[g]),
                    .in_data   (stage_data[g]),
                    .divisor   (heads_eff),
                    .out_valid (stage_valid[g+1]),
                    .out_data  (stage_data[g+1])
                );
            end
        end
    endgenerate

    atatf_fmt u_fmt (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (stage_en[NSTG]),
        .in_valid        (stage_valid[NSTG]),
        .in_data         (stage_data[NSTG]),
        .lba_mode        (lba_mode_reg),
        .out_valid       (m_valid),
        .count_byte      (m_count_byte),
        .sector_byte     (m_sector_byte),
        .cyl_low_byte    (m_cyl_low_byte),
        .cyl_high_byte   (m_cyl_high_byte),
        .drive_head_byte (m_drive_head_byte)
    );

    // checks
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output side is ready");

    a_dh_top_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_drive_head_byte[7])
        else $error("device/head bit 7 set");

    a_dh_lba_nibble: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_drive_head_byte[6]) |-> (m_drive_head_byte[5:4] == 2'b00))
        else $error("lba device/head byte malformed");

    a_dh_chs_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_drive_head_byte[6]) |-> !m_drive_head_byte[5])
        else $error("chs head out of range");

endmodule

`default_nettype wire
